// ===== rtl/salru_pkg.sv =====
// ---------------------------------------------------------------------------
// salru_pkg: shared constants for the set-associative LRU tag store
// Configuration register indexes and port widths fixed by the interface.
// ---------------------------------------------------------------------------
package salru_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  // Reset values of the configuration registers
  localparam logic [2:0] OFFSET_BITS_RST = 3'd3;
  localparam logic [2:0] INDEX_BITS_RST  = 3'd4;
  localparam logic [3:0] WAYS_IN_USE_RST = 4'd8;

  // Fixed payload widths
  localparam int ADDR_W   = 32;
  localparam int VICTIM_W = 32;

endpackage

// ===== rtl/set_assoc_cache_lru_writeback.sv =====
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_writeback: tag store of a write-back, write-allocate
// set-associative cache with per-set LRU ranks
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one access per transaction:
//   func (0 read, 1 write) and a byte address. Output channel
//   (out_valid/out_ready) returns one result per access: hit, dirty_evict,
//   victim_tag, set_index and way_used.
//   The access is captured together with the tag/rank row of its set (read
//   from the row memory, or forwarded from the access ahead of it), then
//   the lookup, victim choice and rank update run combinationally into
//   the result register. One access is taken every cycle while the
//   output is drained.
//   The state of a set is written back when its access moves into the
//   result register; the next access to the same set sees it by forwarding.
//   When out_ready is low with a result waiting, the access in flight holds
//   and in_ready drops until the result register frees.
//   Reset clears the per-line valid bits and restores the configuration
//   registers; tag, dirty and rank rows need no clearing since an invalid
//   line reads as clean with rank zero. Write configuration only when idle.
// ---------------------------------------------------------------------------
module set_assoc_cache_lru_writeback
  import salru_pkg::*;
#(
  parameter int SETS      = 16,
  parameter int WAYS      = 8,
  parameter int TAG_WIDTH = 32,
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // access channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [ADDR_W-1:0]     address,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic                  dirty_evict,
  output logic [VICTIM_W-1:0]   victim_tag,
  output logic [SET_W-1:0]      set_index,
  output logic [WAY_W-1:0]      way_used
);

  localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int IDX_MAX = $clog2(SETS + 1) - 1;

  typedef logic [WAYS-1:0][TAG_WIDTH-1:0] tag_row_t;
  typedef logic [WAYS-1:0][RANK_W-1:0]    rank_row_t;
  typedef logic [WAYS-1:0]                bit_row_t;

  // configuration registers
  logic [2:0] offset_bits;
  logic [2:0] index_bits;
  logic [3:0] ways_in_use;

  // per-line valid bits (cleared at reset) and row memories
  bit_row_t  line_valid [SETS];
  tag_row_t  tag_mem    [SETS];
  bit_row_t  dirty_mem  [SETS];
  rank_row_t rank_mem   [SETS];

  // access stage
  logic                 s_valid;
  logic                 s_func;
  logic [SET_W-1:0]     s_set;
  logic [TAG_WIDTH-1:0] s_tag;
  tag_row_t             s_tags;
  bit_row_t             s_valids;
  bit_row_t             s_dirty;
  rank_row_t            s_rank;

  logic advance;
  logic accept;

  // address split
  logic [2:0]           ib;
  logic [3:0]           tag_shift;
  logic [ADDR_W-1:0]    idx_mask;
  logic [SET_W-1:0]     in_set;
  logic [TAG_WIDTH-1:0] in_tag;
  logic                 fwd;

  // lookup and update
  bit_row_t             active;
  bit_row_t             valid_next;
  bit_row_t             dirty_eff;
  bit_row_t             dirty_next;
  rank_row_t            rank_eff;
  rank_row_t            rank_next;
  tag_row_t             tags_next;
  logic                 hit_c;
  logic [WAY_W-1:0]     hit_way;
  logic                 have_empty;
  logic [WAY_W-1:0]     empty_way;
  logic [RANK_W-1:0]    best;
  logic [WAY_W-1:0]     vic_way;
  logic [WAY_W-1:0]     fill_way;
  logic [RANK_W-1:0]    hit_rank;
  logic                 wb_c;
  logic [VICTIM_W-1:0]  victim_c;

  function automatic logic [RANK_W-1:0] bump(input logic [RANK_W-1:0] r);
    logic [RANK_W-1:0] top;
    top = RANK_W'(WAYS - 1);
    return (r < top) ? r + RANK_W'(1) : r;
  endfunction

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      index_bits  <= INDEX_BITS_RST;
      ways_in_use <= WAYS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_BITS: offset_bits <= cfg_data[2:0];
        CFG_INDEX_BITS:  index_bits  <= cfg_data[2:0];
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Split the incoming address into set and tag
  always_comb begin
    ib = index_bits;
    if ({1'b0, index_bits} > 4'(IDX_MAX)) begin
      ib = 3'(IDX_MAX);
    end
    tag_shift = {1'b0, offset_bits} + {1'b0, ib};
    idx_mask  = (ADDR_W'(1) << ib) - ADDR_W'(1);
    in_set    = SET_W'((address >> offset_bits) & idx_mask);
    in_tag    = TAG_WIDTH'(address >> tag_shift);
  end

  // Forward the row being written when the next access hits the same set
  assign fwd = s_valid && advance && (s_set == in_set);

  // Capture the access and the row of its set
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (advance) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_func <= func;
      s_set  <= in_set;
      s_tag  <= in_tag;
      if (fwd) begin
        s_tags   <= tags_next;
        s_valids <= valid_next;
        s_dirty  <= dirty_next;
        s_rank   <= rank_next;
      end else begin
        s_tags   <= tag_mem[in_set];
        s_valids <= line_valid[in_set];
        s_dirty  <= dirty_mem[in_set];
        s_rank   <= rank_mem[in_set];
      end
    end
  end

  // Look up the set, choose the way and rerank
  always_comb begin
    hit_c      = 1'b0;
    hit_way    = '0;
    have_empty = 1'b0;
    empty_way  = '0;
    best       = '0;
    vic_way    = '0;
    for (int w = 0; w < WAYS; w++) begin
      active[w]    = (w == 0) || ({1'b0, ways_in_use} > 5'(w));
      rank_eff[w]  = s_valids[w] ? s_rank[w] : '0;
      dirty_eff[w] = s_valids[w] && s_dirty[w];
    end
    for (int w = 0; w < WAYS; w++) begin
      if (active[w] && s_valids[w] && (s_tags[w] == s_tag) && !hit_c) begin
        hit_c   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (active[w] && !s_valids[w] && !have_empty) begin
        have_empty = 1'b1;
        empty_way  = WAY_W'(w);
      end
      if (active[w] && (rank_eff[w] > best)) begin
        best    = rank_eff[w];
        vic_way = WAY_W'(w);
      end
    end
    hit_rank = rank_eff[hit_way];
    if (hit_c) begin
      fill_way = hit_way;
    end else if (have_empty) begin
      fill_way = empty_way;
    end else begin
      fill_way = vic_way;
    end

    wb_c     = !hit_c && !have_empty && dirty_eff[vic_way];
    victim_c = wb_c ? VICTIM_W'(s_tags[vic_way]) : '0;

    tags_next  = s_tags;
    valid_next = s_valids;
    dirty_next = dirty_eff;
    for (int w = 0; w < WAYS; w++) begin
      rank_next[w] = rank_eff[w];
      if (active[w]) begin
        if (hit_c) begin
          if (s_valids[w] && (rank_eff[w] < hit_rank)) begin
            rank_next[w] = bump(rank_eff[w]);
          end
        end else if (have_empty) begin
          if (s_valids[w]) begin
            rank_next[w] = bump(rank_eff[w]);
          end
        end else if ((WAY_W'(w) != vic_way) && (rank_eff[w] < best)) begin
          rank_next[w] = bump(rank_eff[w]);
        end
      end
    end
    rank_next[fill_way]  = '0;
    valid_next[fill_way] = 1'b1;
    if (hit_c) begin
      dirty_next[fill_way] = dirty_eff[fill_way] || s_func;
    end else begin
      dirty_next[fill_way] = s_func;
      tags_next[fill_way]  = s_tag;
    end
  end

  // Commit the set state as the access leaves the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        line_valid[s] <= '0;
      end
    end else if (s_valid && advance) begin
      line_valid[s_set] <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && advance) begin
      tag_mem[s_set]   <= tags_next;
      dirty_mem[s_set] <= dirty_next;
      rank_mem[s_set]  <= rank_next;
    end
  end

  // Hold the result until the receiver takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_valid) begin
      hit         <= hit_c;
      dirty_evict <= wb_c;
      victim_tag  <= victim_c;
      set_index   <= s_set;
      way_used    <= fill_way;
    end
  end

endmodule

// ===== tb/sv/set_assoc_cache_lru_writeback_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_writeback_test: self-checking bench for the LRU tag store
// Drives read/write accesses through the valid/ready access channel, predicts
// hit, write-back, victim tag, set and way for each one with a behavioral
// copy of the tag store, and compares every result transaction in order.
// Directed tests cover fill, hit, clean and dirty eviction, way limits and
// address extremes; random phases sweep the geometry and idle patterns.
// ---------------------------------------------------------------------------
module set_assoc_cache_lru_writeback_test
  import salru_pkg::*;
();

  localparam int SETS       = 16;
  localparam int WAYS       = 8;
  localparam int MAX_IB     = 4;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 6;

  typedef struct packed {
    logic        hit;
    logic        dirty_evict;
    logic [31:0] victim_tag;
    logic [3:0]  set_index;
    logic [2:0]  way_used;
  } lookup_result_t;

  // DUT ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  func = 1'b0;
  logic [ADDR_W-1:0]     address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  hit;
  logic                  dirty_evict;
  logic [VICTIM_W-1:0]   victim_tag;
  logic [3:0]            set_index;
  logic [2:0]            way_used;

  // Shadow tag store and configuration
  bit          line_valid_q [SETS*WAYS];
  bit          line_dirty_q [SETS*WAYS];
  logic [31:0] line_tag_q   [SETS*WAYS];
  bit   [2:0]  line_age_q   [SETS*WAYS];
  logic [2:0]  offset_bits_q = OFFSET_BITS_RST;
  logic [2:0]  index_bits_q  = INDEX_BITS_RST;
  logic [3:0]  ways_q        = WAYS_IN_USE_RST;

  lookup_result_t expected_lookups [$];
  lookup_result_t oldest_lookup;
  int             mismatches = 0;
  int             idle_cycles = 0;
  int             send_gap_pct = 0;
  int             stall_pct = 0;

  set_assoc_cache_lru_writeback dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .address     (address),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .dirty_evict (dirty_evict),
    .victim_tag  (victim_tag),
    .set_index   (set_index),
    .way_used    (way_used)
  );

  always #10 clk = ~clk;

  // Geometry after clamping
  function automatic int eff_index_bits();
    return (index_bits_q > MAX_IB) ? MAX_IB : int'(index_bits_q);
  endfunction

  function automatic int eff_ways();
    if (ways_q == 0) return 1;
    return (ways_q > WAYS) ? WAYS : int'(ways_q);
  endfunction

  function automatic bit [2:0] age_up(input bit [2:0] age);
    return (age < WAYS - 1) ? age + 3'd1 : age;
  endfunction

  // Look up one access in the shadow store, update it, return the result
  function automatic lookup_result_t cache_lookup(input bit wr, input logic [31:0] addr);
    lookup_result_t res;
    int             ib, nw, base, way;
    logic [31:0]    set_mask, tg, st;
    bit             found, empty;
    bit   [2:0]     cur, top;
    ib = eff_index_bits();
    nw = eff_ways();
    set_mask = (32'd1 << ib) - 32'd1;
    st = (addr >> offset_bits_q) & set_mask;
    tg = addr >> (offset_bits_q + ib);
    base = int'(st) * WAYS;
    found = 1'b0;
    empty = 1'b0;
    way = 0;
    res = '0;
    for (int w = 0; w < nw; w++) begin
      if (!found && line_valid_q[base+w] && line_tag_q[base+w] == tg) begin
        found = 1'b1;
        way = w;
      end
    end
    if (found) begin
      // promote the hit line, age the younger valid lines
      cur = line_age_q[base+way];
      for (int w = 0; w < nw; w++)
        if (line_valid_q[base+w] && line_age_q[base+w] < cur)
          line_age_q[base+w] = age_up(line_age_q[base+w]);
      line_age_q[base+way] = 3'd0;
      if (wr) line_dirty_q[base+way] = 1'b1;
    end else begin
      for (int w = 0; w < nw; w++) begin
        if (!empty && !line_valid_q[base+w]) begin
          empty = 1'b1;
          way = w;
        end
      end
      if (empty) begin
        for (int w = 0; w < nw; w++)
          if (line_valid_q[base+w]) line_age_q[base+w] = age_up(line_age_q[base+w]);
      end else begin
        // oldest line goes; ties resolve to the lowest way
        top = 3'd0;
        way = 0;
        for (int w = 0; w < nw; w++) begin
          if (line_age_q[base+w] > top) begin
            top = line_age_q[base+w];
            way = w;
          end
        end
        if (line_dirty_q[base+way]) begin
          res.dirty_evict = 1'b1;
          res.victim_tag  = line_tag_q[base+way];
        end
        for (int w = 0; w < nw; w++)
          if (w != way && line_age_q[base+w] < top)
            line_age_q[base+w] = age_up(line_age_q[base+w]);
      end
      line_valid_q[base+way] = 1'b1;
      line_tag_q[base+way]   = tg;
      line_dirty_q[base+way] = wr;
      line_age_q[base+way]   = 3'd0;
    end
    res.hit       = found;
    res.set_index = st[3:0];
    res.way_used  = way[2:0];
    return res;
  endfunction

  // Build an address that lands on a given tag and set under the current geometry
  function automatic logic [31:0] addr_for(input logic [31:0] tg, input logic [31:0] st,
                                           input logic [31:0] low);
    int ib;
    ib = eff_index_bits();
    return (tg << (offset_bits_q + ib)) | (st << offset_bits_q) |
           (low & ((32'd1 << offset_bits_q) - 32'd1));
  endfunction

  // Send one access; returns at a falling edge with valid still high
  task automatic send_access(input bit wr, input logic [31:0] addr);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= wr;
    address  <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_lookups.push_back(cache_lookup(wr, addr));
    @(negedge clk);
  endtask

  // Drop valid and hold until every result has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_OFFSET_BITS: offset_bits_q = val[2:0];
      CFG_INDEX_BITS:  index_bits_q  = val[2:0];
      CFG_WAYS_IN_USE: ways_q        = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [3:0] off, input logic [3:0] ib,
                              input logic [3:0] ways);
    wait_idle();
    write_reg(CFG_OFFSET_BITS, off);
    write_reg(CFG_INDEX_BITS, ib);
    write_reg(CFG_WAYS_IN_USE, ways);
  endtask

  // Cold miss, read hit and write hit on set 0; write miss, then read hit on the top set
  task automatic test_hit_and_fill();
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'hFFFF_FFFF);
  endtask

  // Fill a set, then evict the dirty oldest line and then a clean one
  task automatic test_eviction();
    send_access(1'b1, addr_for(32'h100, 2, 0));
    for (int t = 1; t < WAYS; t++) send_access(1'b0, addr_for(32'h100 + t, 2, t));
    send_access(1'b0, addr_for(32'h108, 2, 0));
    send_access(1'b1, addr_for(32'h109, 2, 5));
  endtask

  // Shrink and grow the active ways: duplicate tags, clamped way counts
  task automatic test_way_limits();
    send_access(1'b1, addr_for(32'h20, 3, 0));
    send_access(1'b0, addr_for(32'h21, 3, 0));
    set_geometry(3, 4, 1);
    send_access(1'b0, addr_for(32'h21, 3, 0));
    set_geometry(3, 4, 15);
    send_access(1'b0, addr_for(32'h21, 3, 0));
    set_geometry(3, 4, 0);
    send_access(1'b0, addr_for(32'h22, 3, 0));
  endtask

  // Widest offset with clamped index, then no offset and no index
  task automatic test_field_extremes();
    set_geometry(7, 7, 8);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'hFFFF_FFFF);
    send_access(1'b0, 32'h0000_0000);
    set_geometry(0, 0, 8);
    send_access(1'b0, 32'hFFFF_FFFF);
    send_access(1'b1, 32'h0000_0000);
  endtask

  // One random phase: mostly a small tag pool per set, some raw addresses
  task automatic run_phase(input logic [3:0] off, input logic [3:0] ib, input logic [3:0] ways,
                           input int gap, input int stall, input int count, input bit pause);
    logic [31:0] tag_base, addr;
    int          nw, sets;
    set_geometry(off, ib, ways);
    send_gap_pct = gap;
    stall_pct    = stall;
    nw   = eff_ways();
    sets = 1 << eff_index_bits();
    tag_base = ($urandom_range(0, 3) == 0) ? $urandom() : 32'h0;
    for (int i = 0; i < count; i++) begin
      if (pause && i == count / 2) wait_idle();
      if ($urandom_range(0, 99) < 15)
        addr = $urandom();
      else
        addr = addr_for(tag_base + $urandom_range(0, nw + 2), $urandom_range(0, sets - 1),
                        $urandom());
      send_access(1'($urandom_range(0, 1)), addr);
    end
  endtask

  task automatic test_random_traffic();
    run_phase(3, 4, 8,  0,  0,  200, 1'b0);
    run_phase(0, 0, 1,  73, 0,  150, 1'b0);
    run_phase(6, 2, 4,  0,  73, 200, 1'b1);
    run_phase(7, 7, 15, 14, 14, 200, 1'b0);
    run_phase(2, 3, 0,  0,  0,  150, 1'b0);
    run_phase(5, 1, 3,  73, 0,  150, 1'b0);
    run_phase(1, 4, 8,  0,  73, 200, 1'b0);
    run_phase(4, 2, 6,  14, 14, 200, 1'b0);
    run_phase(0, 4, 2,  0,  0,  150, 1'b0);
  endtask

  // Receiver: randomized back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: result with nothing expected: hit %0b set %0h way %0h",
                 $time, hit, set_index, way_used);
        mismatches++;
      end else begin
        oldest_lookup = expected_lookups.pop_front();
        check_field("hit", 32'(oldest_lookup.hit), 32'(hit));
        check_field("dirty_evict", 32'(oldest_lookup.dirty_evict), 32'(dirty_evict));
        check_field("victim_tag", oldest_lookup.victim_tag, victim_tag);
        check_field("set_index", 32'(oldest_lookup.set_index), 32'(set_index));
        check_field("way_used", 32'(oldest_lookup.way_used), 32'(way_used));
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_hit_and_fill();
    test_eviction();
    test_way_limits();
    test_field_extremes();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== set_assoc_cache_lru_writeback.f =====
rtl/salru_pkg.sv
rtl/set_assoc_cache_lru_writeback.sv
tb/sv/set_assoc_cache_lru_writeback_test.sv
